// File: rtl/worker_slot_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Worker slot allocator assertion macros
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WORKER_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define WORKER_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, idle during reset
`define WSA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, idle during reset
`define WSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/wsa_pkg.sv
// ----------------------------------------------------------------------------
// Worker slot allocator package
// Beat types, register indexes, micro-operations and the control store.
// ----------------------------------------------------------------------------
package wsa_pkg;

   localparam int SLOTS_DEF   = 8;
   localparam int MAX_RESULTS = 8;
   localparam int RES_IDX_W   = 3;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_POOL_SIZE   = 2'd0;
   localparam logic [1:0] CSR_GRANT_COUNT = 2'd1;
   localparam logic [1:0] CSR_MACHINE_ID  = 2'd2;

   localparam logic [3:0] POOL_SIZE_RESET   = 4'd8;
   localparam logic [3:0] GRANT_COUNT_RESET = 4'd1;
   localparam logic [7:0] MACHINE_ID_RESET  = 8'd0;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [2:0] slot;
      logic [7:0] owner_machine;
   } req_type;

   typedef struct packed {
      logic [2:0] slot_res;
      logic       done_res;
      logic [3:0] busy_count;
      logic       full_res;
      logic       last;
   } rsp_type;

   // Control store addressing
   localparam int PC_W = 3;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_IDLE       = 3'd0;
   localparam pc_type PC_DISPATCH   = 3'd1;
   localparam pc_type PC_SCAN       = 3'd2;
   localparam pc_type PC_ALLOC_FULL = 3'd3;
   localparam pc_type PC_ALLOC_EMIT = 3'd4;
   localparam pc_type PC_RELEASE    = 3'd5;
   localparam pc_type PC_REL_EMIT   = 3'd6;

   typedef enum logic [2:0] {
      OP_NOP        = 3'd0,
      OP_LOAD       = 3'd1,
      OP_SCAN       = 3'd2,
      OP_FULL_SET   = 3'd3,
      OP_EMIT_ALLOC = 3'd4,
      OP_RELEASE    = 3'd5,
      OP_EMIT_REL   = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      C_ALWAYS      = 3'd0,
      C_START       = 3'd1,
      C_RELEASE     = 3'd2,
      C_SCAN_ACTIVE = 3'd3,
      C_EMIT_MORE   = 3'd4
   } cond_sel_type;

   typedef struct packed {
      op_type       op;
      cond_sel_type cond;
      pc_type       jump;
      pc_type       next;
   } mc_word_type;

   // Condition flags from the datapath
   typedef struct packed {
      logic start;
      logic release_item;
      logic scan_active;
      logic emit_more;
   } cond_type;

   // Sequencer outputs to the datapath
   typedef struct packed {
      op_type op;
      logic   idle;
   } ctrl_type;

   // Microprogram: taken jump when the condition holds, else the next field
   function automatic mc_word_type mc_rom(input pc_type pc);
      mc_word_type w;
      unique case (pc)
         PC_IDLE:       w = '{OP_LOAD,       C_START,       PC_DISPATCH,   PC_IDLE};
         PC_DISPATCH:   w = '{OP_NOP,        C_RELEASE,     PC_RELEASE,    PC_SCAN};
         PC_SCAN:       w = '{OP_SCAN,       C_SCAN_ACTIVE, PC_SCAN,       PC_ALLOC_FULL};
         PC_ALLOC_FULL: w = '{OP_FULL_SET,   C_ALWAYS,      PC_ALLOC_EMIT, PC_ALLOC_EMIT};
         PC_ALLOC_EMIT: w = '{OP_EMIT_ALLOC, C_EMIT_MORE,   PC_ALLOC_EMIT, PC_IDLE};
         PC_RELEASE:    w = '{OP_RELEASE,    C_ALWAYS,      PC_REL_EMIT,   PC_REL_EMIT};
         PC_REL_EMIT:   w = '{OP_EMIT_REL,   C_ALWAYS,      PC_IDLE,       PC_IDLE};
         default:       w = '{OP_NOP,        C_ALWAYS,      PC_IDLE,       PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

// File: rtl/wsa_seq.sv
// ----------------------------------------------------------------------------
// Worker slot allocator sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module wsa_seq (
   input  logic              clock,
   input  logic              reset,
   input  wsa_pkg::cond_type cond,
   output wsa_pkg::ctrl_type ctrl
);
   import wsa_pkg::*;

   pc_type      pc_ff;
   pc_type      pc_in;
   mc_word_type word;
   logic        taken;

   // Fetch the control word of this step
   assign word = mc_rom(pc_ff);

   // Select the jump condition
   always_comb begin
      unique case (word.cond)
         C_ALWAYS:      taken = 1'b1;
         C_START:       taken = cond.start;
         C_RELEASE:     taken = cond.release_item;
         C_SCAN_ACTIVE: taken = cond.scan_active;
         C_EMIT_MORE:   taken = cond.emit_more;
         default:       taken = 1'b1;
      endcase
   end

   assign pc_in = taken ? word.jump : word.next;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op   = word.op;
   assign ctrl.idle = (pc_ff == PC_IDLE);

endmodule

// File: rtl/worker_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// Worker slot allocator
// Busy bitmap allocator over the worker slots of one machine, run by a
// microprogram over a small datapath.
// ----------------------------------------------------------------------------
// Channel   Ports                               Handshake
// request   start, busy, req_data               beat taken when start & !busy
// result    rsp_valid, rsp_data                 one-cycle strobe, no back-pressure
// config    csr_we, csr_index, csr_wdata        write when csr_we, no wait
//
// Allocate: dispatch, a scan loop testing one slot per step, the full-flag
// step and an emit loop, results registered. Release: dispatch, the release
// step and one emit step for its single result. busy is high from the cycle
// after start through the last emit step and is already low in the cycle
// that carries the last result; nothing stalls. Reset is synchronous: it
// clears bitmap, full flag and strobe; idle count and config take reset values.
// ----------------------------------------------------------------------------
module worker_slot_allocator_top #(
   parameter int SLOTS = wsa_pkg::SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  wsa_pkg::req_type req_data,
   output logic             rsp_valid,
   output wsa_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata
);
   import wsa_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

   // Configuration registers
   logic [3:0] pool_size_ff;
   logic [3:0] grant_count_ff;
   logic [7:0] machine_id_ff;

   // Allocator state
   logic [SLOTS-1:0] busy_map_ff,  busy_map_in;
   logic [3:0]       idle_ff,      idle_in;
   logic             full_ff,      full_in;

   // Item and working registers
   req_type          item_ff,      item_in;
   logic [CNT_W-1:0] scan_ff,      scan_in;
   logic [3:0]       n_ff,         n_in;
   logic [2:0]       k_ff,         k_in;
   logic             done_ff,      done_in;
   logic [2:0]       list_ff [MAX_RESULTS];
   logic             list_we;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff,       rsp_in;

   ctrl_type ctrl;
   cond_type cond;

   logic [CMP_W-1:0] pool_w;
   logic [3:0]       want;
   logic [IDX_W-1:0] scan_idx;
   logic [IDX_W-1:0] rel_idx;
   logic             scan_active;
   logic             last_beat;
   logic             rel_hit;
   logic [3:0]       busy_now;

   wsa_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   // Clamp pool to the slot count and the wanted grants to the result limit
   always_comb begin
      if (CMP_W'(pool_size_ff) < CMP_W'(SLOTS)) begin
         pool_w = CMP_W'(pool_size_ff);
      end else begin
         pool_w = CMP_W'(SLOTS);
      end
      if (grant_count_ff < 4'(MAX_RESULTS)) begin
         want = grant_count_ff;
      end else begin
         want = 4'(MAX_RESULTS);
      end
   end

   assign scan_idx    = scan_ff[IDX_W-1:0];
   assign rel_idx     = IDX_W'(item_ff.slot);
   assign scan_active = (CMP_W'(scan_ff) < pool_w) && (n_ff < want);
   assign last_beat   = (n_ff == 4'd0) || ({1'b0, k_ff} + 4'd1 == n_ff);
   assign rel_hit     = (item_ff.owner_machine == machine_id_ff)
                     && (CMP_W'(item_ff.slot) < CMP_W'(SLOTS))
                     && busy_map_ff[rel_idx];
   assign busy_now    = (idle_ff > pool_size_ff) ? 4'd0 : (pool_size_ff - idle_ff);

   assign cond.start        = start;
   assign cond.release_item = (item_ff.kind == KIND_RELEASE);
   assign cond.scan_active  = scan_active;
   assign cond.emit_more    = !last_beat;

   // Datapath actions of each micro-operation
   always_comb begin
      busy_map_in  = busy_map_ff;
      idle_in      = idle_ff;
      full_in      = full_ff;
      item_in      = item_ff;
      scan_in      = scan_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      done_in      = done_ff;
      list_we      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (ctrl.op)
         OP_NOP: begin
         end
         OP_LOAD: begin
            if (start) begin
               item_in = req_data;
               scan_in = '0;
               n_in    = 4'd0;
               k_in    = 3'd0;
            end
         end
         OP_SCAN: begin
            if (scan_active) begin
               scan_in = scan_ff + CNT_W'(1);
               if (!busy_map_ff[scan_idx]) begin
                  busy_map_in[scan_idx] = 1'b1;
                  if (idle_ff != 4'd0) begin
                     idle_in = idle_ff - 4'd1;
                  end
                  list_we = 1'b1;
                  n_in    = n_ff + 4'd1;
               end
            end
         end
         OP_FULL_SET: begin
            if (idle_ff < grant_count_ff) begin
               full_in = 1'b1;
            end
         end
         OP_EMIT_ALLOC: begin
            rsp_valid_in      = 1'b1;
            rsp_in.slot_res   = (n_ff == 4'd0) ? 3'd0 : list_ff[k_ff];
            rsp_in.done_res   = (n_ff != 4'd0);
            rsp_in.busy_count = busy_now;
            rsp_in.full_res   = full_ff;
            rsp_in.last       = last_beat;
            k_in              = k_ff + 3'd1;
         end
         OP_RELEASE: begin
            done_in = rel_hit;
            if (rel_hit) begin
               busy_map_in[rel_idx] = 1'b0;
               if (idle_ff != 4'hF) begin
                  idle_in = idle_ff + 4'd1;
               end
            end
            if (idle_in >= grant_count_ff) begin
               full_in = 1'b0;
            end
         end
         OP_EMIT_REL: begin
            rsp_valid_in      = 1'b1;
            rsp_in.slot_res   = item_ff.slot;
            rsp_in.done_res   = done_ff;
            rsp_in.busy_count = busy_now;
            rsp_in.full_res   = full_ff;
            rsp_in.last       = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Hold configuration; write on the enable
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff   <= POOL_SIZE_RESET;
         grant_count_ff <= GRANT_COUNT_RESET;
         machine_id_ff  <= MACHINE_ID_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POOL_SIZE:   pool_size_ff   <= csr_wdata[3:0];
            CSR_GRANT_COUNT: grant_count_ff <= csr_wdata[3:0];
            CSR_MACHINE_ID:  machine_id_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Advance allocator state and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_map_ff  <= '0;
         idle_ff      <= POOL_SIZE_RESET;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_map_ff  <= busy_map_in;
         idle_ff      <= idle_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      scan_ff <= scan_in;
      n_ff    <= n_in;
      k_ff    <= k_in;
      done_ff <= done_in;
      rsp_ff  <= rsp_in;
      if (list_we) begin
         list_ff[n_ff[RES_IDX_W-1:0]] <= 3'(scan_ff);
      end
   end

   assign busy      = !ctrl.idle;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/wsa_checker.sv
// ----------------------------------------------------------------------------
// Worker slot allocator port checker
// Watches the top level's ports for ordering of start, busy and result beats.
// ----------------------------------------------------------------------------
`include "worker_slot_allocator_top_assert.svh"

module wsa_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input wsa_pkg::rsp_type rsp_data,
   input logic             rsp_valid
);
   import wsa_pkg::*;

   // An accepted beat keeps the block occupied
   `WSA_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "busy did not rise after start")

   // Grants of one item follow one another without gaps
   `WSA_ASSERT_NEXT(a_grant_burst, clock, reset, rsp_valid && !rsp_data.last, rsp_valid, "gap in result burst")

   // A refused or failed beat is always the only one of its item
   `WSA_ASSERT_SAME(a_fail_last, clock, reset, rsp_valid && !rsp_data.done_res, rsp_data.last, "failed result not last")

   // More results pending means the block is still occupied
   `WSA_ASSERT_SAME(a_more_busy, clock, reset, rsp_valid && !rsp_data.last, busy, "idle with results pending")

endmodule

bind worker_slot_allocator_top wsa_checker u_wsa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);
